// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the text cleanup filter RTL.
// No dependencies; modules that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of clk while rst_n is high.
`define TCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define TCF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCF_ASSERT(lbl, prop, msg)
`define TCF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/tcf_pkg.sv
// Constants, the command type and the byte folding table of the text cleanup filter.
// No dependencies; used by every RTL module and by the testbench.
`default_nettype none

package tcf_pkg;

  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_NL       = 8'd10;
  localparam logic [7:0] CH_CTRL_MAX = 8'd31;
  localparam logic [7:0] CH_HIGH_MIN = 8'd127;
  localparam logic [7:0] CH_DROP     = 8'd0;

  localparam int TAB_SPACES = 7;
  localparam int TAB_CNT_W  = $clog2(TAB_SPACES);
  localparam logic [TAB_CNT_W-1:0] TAB_LAST = TAB_CNT_W'(TAB_SPACES - 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QCNT_W-1:0] QUEUE_FULL = QCNT_W'(QUEUE_DEPTH);

  typedef struct packed {
    logic       is_tab;
    logic [7:0] ch;
  } tcf_cmd_t;

  // Maps a byte that is neither space, tab nor newline; CH_DROP means no output.
  function automatic logic [7:0] map_byte(input logic [7:0] b);
    logic [7:0] c;
    if (b >= 8'd192 && b <= 8'd195) c = 8'd65;
    else if (b == 8'd199) c = 8'd67;
    else if (b == 8'd201 || b == 8'd202) c = 8'd69;
    else if (b == 8'd205) c = 8'd73;
    else if (b >= 8'd211 && b <= 8'd213) c = 8'd79;
    else if (b == 8'd218) c = 8'd85;
    else if (b >= 8'd224 && b <= 8'd227) c = 8'd97;
    else if (b == 8'd231) c = 8'd99;
    else if (b == 8'd233 || b == 8'd234) c = 8'd101;
    else if (b == 8'd237) c = 8'd105;
    else if (b >= 8'd243 && b <= 8'd245) c = 8'd111;
    else if (b == 8'd250) c = 8'd117;
    else if (b >= CH_HIGH_MIN) c = CH_SPACE;
    else if (b > CH_CTRL_MAX) c = b;
    else c = CH_DROP;
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tcf_if.sv
// Valid/ready channel interfaces for the text cleanup filter input and output items.
// No dependencies.
`default_nettype none

interface tcf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;
  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface tcf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;
  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/text_cleanup_filter_unit.sv
// Top level of the text cleanup filter: front end, command queue and output sequencer.
// Depends on tcf_pkg, tcf_if, tcf_front, tcf_cmd_queue and tcf_back.
//
//   channel  dir  fields                     handshake
//   in_ch    in   in_byte[7:0], end_of_text  valid/ready
//   out_ch   out  out_char[7:0], last_of_run valid/ready
//
// An input item is taken every cycle while the four-entry command queue has room.
// A byte that gives one output leaves one item per cycle while out_ch is ready;
// a tab holds the output sequencer while its seven spaces drain; the queue absorbs input.
// Dropped bytes, collapsed spaces and end of text after a newline give no output.
// Results leave from an output register loaded from the command at the queue head.
// Reset is synchronous, active low, and returns the text state to start of text.
`default_nettype none

module text_cleanup_filter_unit
  import tcf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  tcf_in_if.sink    in_ch,
  tcf_out_if.source out_ch
);

  logic     push_valid;
  logic     push_ready;
  tcf_cmd_t push_cmd;
  logic     pop_valid;
  logic     pop_ready;
  tcf_cmd_t pop_cmd;

  tcf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  tcf_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  tcf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// File: hw/rtl/tcf_front.sv
// Front end: accepts input items, tracks text state and issues output commands.
// Depends on tcf_pkg and tcf_in_if.
`default_nettype none

module tcf_front
  import tcf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  tcf_in_if.sink    in_ch,
  output logic      push_valid,
  input  wire logic push_ready,
  output tcf_cmd_t  push_cmd
);

  logic prev_nl_r, prev_nl_nxt;
  logic at_start_r, at_start_nxt;
  logic in_run_r, in_run_nxt;
  logic keeps_r, keeps_nxt;
  logic emit;
  logic accept;
  logic [7:0] mapped;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;
  assign push_valid  = in_ch.valid && emit;
  assign mapped      = map_byte(in_ch.in_byte);

  always_comb begin
    prev_nl_nxt     = prev_nl_r;
    at_start_nxt    = at_start_r;
    in_run_nxt      = in_run_r;
    keeps_nxt       = keeps_r;
    emit            = 1'b0;
    push_cmd.is_tab = 1'b0;
    push_cmd.ch     = in_ch.in_byte;
    if (in_ch.end_of_text) begin
      emit         = !prev_nl_r;
      push_cmd.ch  = CH_NL;
      prev_nl_nxt  = 1'b0;
      at_start_nxt = 1'b1;
      in_run_nxt   = 1'b0;
      keeps_nxt    = 1'b0;
    end else begin
      if (in_ch.in_byte == CH_SPACE) begin
        if (!in_run_r) begin
          keeps_nxt  = prev_nl_r || at_start_r;
          in_run_nxt = 1'b1;
          emit       = 1'b1;
        end else begin
          emit = keeps_r;
        end
      end else begin
        in_run_nxt = 1'b0;
        keeps_nxt  = 1'b0;
        if (in_ch.in_byte == CH_TAB) begin
          emit            = 1'b1;
          push_cmd.is_tab = 1'b1;
          push_cmd.ch     = CH_SPACE;
        end else if (in_ch.in_byte == CH_NL) begin
          emit = 1'b1;
        end else begin
          emit        = (mapped != CH_DROP);
          push_cmd.ch = mapped;
        end
      end
      prev_nl_nxt  = (in_ch.in_byte == CH_NL);
      at_start_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_nl_r  <= 1'b0;
      at_start_r <= 1'b1;
      in_run_r   <= 1'b0;
      keeps_r    <= 1'b0;
    end else if (accept) begin
      prev_nl_r  <= prev_nl_nxt;
      at_start_r <= at_start_nxt;
      in_run_r   <= in_run_nxt;
      keeps_r    <= keeps_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tcf_cmd_queue.sv
// Small command queue between the front end and the output sequencer.
// Depends on tcf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tcf_cmd_queue
  import tcf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push_valid,
  output logic          push_ready,
  input  wire tcf_cmd_t push_cmd,
  output logic          pop_valid,
  input  wire logic     pop_ready,
  output tcf_cmd_t      pop_cmd
);

  tcf_cmd_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QUEUE_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  `TCF_ASSERT(a_count_bound, count_r <= QUEUE_FULL, "Queue count exceeds its depth.")
  `TCF_ASSERT(a_ptr_gap, (count_r == '0 || count_r == QUEUE_FULL) |-> (wr_ptr_r == rd_ptr_r),
              "Queue pointers disagree with an empty or full count.")

endmodule

`default_nettype wire

// File: hw/rtl/tcf_back.sv
// Output sequencer: expands queued commands into output items through an output register.
// Depends on tcf_pkg, tcf_out_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tcf_back
  import tcf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cmd_valid,
  output logic          cmd_ready,
  input  wire tcf_cmd_t cmd,
  tcf_out_if.source     out_ch
);

  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [TAB_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 load_en;
  logic                 cmd_last;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_char    = out_char_r;
  assign out_ch.last_of_run = out_last_r;

  assign load_en   = !out_valid_r || out_ch.ready;
  assign cmd_last  = !cmd.is_tab || (cnt_r == TAB_LAST);
  assign cmd_ready = load_en && cmd_last;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    cnt_nxt       = cnt_r;
    if (load_en) begin
      out_valid_nxt = cmd_valid;
      if (cmd_valid) begin
        out_char_nxt = cmd.ch;
        out_last_nxt = cmd_last;
        if (cmd.is_tab) begin
          cnt_nxt = cmd_last ? '0 : cnt_r + TAB_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  `TCF_ASSERT(a_tab_in_progress, (cnt_r != '0) |-> (cmd_valid && cmd.is_tab && out_valid_r),
              "Tab expansion count is active without a tab command at the queue head.")
  `TCF_ASSERT(a_tab_not_last, (cnt_r != '0) |-> !out_last_r,
              "A partial tab expansion was marked as the last item of its run.")

endmodule

`default_nettype wire

// File: test/text_cleanup_filter_unit_tb.sv
// Testbench for text_cleanup_filter_unit: drives byte items, predicts the cleaned stream
// and checks every result item. Depends on tcf_pkg, tcf_if and the filter RTL.
`default_nettype none

typedef struct {
  logic [7:0] ch;
  logic       last;
} cleaned_char_t;

class cleanup_scoreboard;
  cleaned_char_t expected_chars[$];
  int unsigned   mismatches;
  bit            nl_last;
  bit            text_fresh;
  bit            spaces_open;
  bit            spaces_kept;

  function new();
    mismatches = 0;
    restart_text();
  endfunction

  function void restart_text();
    nl_last     = 1'b0;
    text_fresh  = 1'b1;
    spaces_open = 1'b0;
    spaces_kept = 1'b0;
  endfunction

  function void push_char(logic [7:0] ch, logic last);
    cleaned_char_t r;
    r.ch   = ch;
    r.last = last;
    expected_chars.push_back(r);
  endfunction

  function logic [7:0] fold_char(logic [7:0] b);
    logic [7:0] c;
    case (b)
      8'd192, 8'd193, 8'd194, 8'd195: c = "A";
      8'd199:                         c = "C";
      8'd201, 8'd202:                 c = "E";
      8'd205:                         c = "I";
      8'd211, 8'd212, 8'd213:         c = "O";
      8'd218:                         c = "U";
      8'd224, 8'd225, 8'd226, 8'd227: c = "a";
      8'd231:                         c = "c";
      8'd233, 8'd234:                 c = "e";
      8'd237:                         c = "i";
      8'd243, 8'd244, 8'd245:         c = "o";
      8'd250:                         c = "u";
      default: begin
        if (b >= tcf_pkg::CH_HIGH_MIN) c = tcf_pkg::CH_SPACE;
        else if (b > tcf_pkg::CH_CTRL_MAX) c = b;
        else c = tcf_pkg::CH_DROP;
      end
    endcase
    return c;
  endfunction

  function void note_input(logic [7:0] b, logic eot);
    logic [7:0] c;
    if (eot) begin
      if (!nl_last) push_char(tcf_pkg::CH_NL, 1'b1);
      restart_text();
      return;
    end
    if (b == tcf_pkg::CH_SPACE) begin
      if (!spaces_open) begin
        spaces_kept = nl_last || text_fresh;
        spaces_open = 1'b1;
        push_char(tcf_pkg::CH_SPACE, 1'b1);
      end else if (spaces_kept) begin
        push_char(tcf_pkg::CH_SPACE, 1'b1);
      end
    end else begin
      spaces_open = 1'b0;
      spaces_kept = 1'b0;
      if (b == tcf_pkg::CH_TAB) begin
        for (int i = 0; i < tcf_pkg::TAB_SPACES; i++)
          push_char(tcf_pkg::CH_SPACE, i == tcf_pkg::TAB_SPACES - 1);
      end else if (b == tcf_pkg::CH_NL) begin
        push_char(tcf_pkg::CH_NL, 1'b1);
      end else begin
        c = fold_char(b);
        if (c != tcf_pkg::CH_DROP) push_char(c, 1'b1);
      end
    end
    nl_last    = (b == tcf_pkg::CH_NL);
    text_fresh = 1'b0;
  endfunction

  task report_mismatch(string what);
    $display("MISMATCH: %s", what);
    mismatches++;
  endtask

  task check_result(logic [7:0] ch, logic last);
    cleaned_char_t r;
    if (expected_chars.size() == 0) begin
      report_mismatch($sformatf("unexpected item char=%0d last=%0b", ch, last));
      return;
    end
    r = expected_chars.pop_front();
    if (ch !== r.ch)
      report_mismatch($sformatf("out_char %0d, expected %0d", ch, r.ch));
    if (last !== r.last)
      report_mismatch($sformatf("last_of_run %0b, expected %0b (char %0d)", last, r.last, r.ch));
  endtask

  function int unsigned pending();
    return expected_chars.size();
  endfunction
endclass

module text_cleanup_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RANDOM_ITEMS = 230;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_byte_d = 8'd0;
  logic in_eot = 1'b0;
  logic out_ready = 1'b0;
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;
  int unsigned out_stall = 0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;

  cleanup_scoreboard sb = new();

  tcf_in_if  in_ch();
  tcf_out_if out_ch();

  assign in_ch.valid       = in_valid;
  assign in_ch.in_byte     = in_byte_d;
  assign in_ch.end_of_text = in_eot;
  assign out_ch.ready      = out_ready;

  text_cleanup_filter_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned gap_length(bit short_only);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85 || short_only) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready = 1'b0;
      out_stall--;
    end else begin
      out_ready = 1'b1;
      if (!quiet_out && $urandom_range(0, 3) == 0) out_stall = gap_length(1'b0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else if (rst_n) begin
      if (in_valid && in_ch.ready) sb.note_input(in_byte_d, in_eot);
      if (out_ch.valid && out_ready) sb.check_result(out_ch.out_char, out_ch.last_of_run);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eot);
    int unsigned gap;
    @(negedge clk);
    gap = 0;
    if (!quiet_in && $urandom_range(0, 99) < 45) gap = gap_length(1'b0);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_byte_d = b;
    in_eot    = eot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(b, 1'b0);
  endtask

  task automatic send_eot();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] text_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 8'($urandom_range(33, 126));
    if (r < 65) return tcf_pkg::CH_SPACE;
    if (r < 72) return tcf_pkg::CH_NL;
    if (r < 77) return tcf_pkg::CH_TAB;
    if (r < 82) return 8'($urandom_range(192, 255));
    if (r < 85) return 8'($urandom_range(127, 255));
    if (r < 90) return 8'($urandom_range(0, 31));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_text();
    int unsigned len;
    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
    for (int unsigned i = 0; i < len; i++) send_byte(text_byte());
    send_eot();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Leading spaces are kept, later runs collapse, tab breaks a run.
    send_byte(8'd32);
    send_byte(8'd32);
    send_byte(8'd65);
    send_byte(8'd32);
    send_byte(8'd32);
    send_byte(8'd32);
    send_byte(tcf_pkg::CH_TAB);
    send_byte(8'd32);
    send_byte(8'd32);
    send_byte(8'd0);
    send_byte(8'd32);
    send_byte(tcf_pkg::CH_NL);
    send_byte(8'd32);
    send_byte(8'd32);
    send_byte(8'd255);
    send_byte(8'd127);
    send_byte(8'd192);
    send_byte(8'd250);
    send_byte(8'd199);
    send_byte(tcf_pkg::CH_NL);
    send_eot();
    send_eot();
    // A dropped control byte at the start of a text ends the start-of-text run.
    send_byte(8'd31);
    send_byte(8'd32);
    send_byte(8'd32);
    send_eot();

    while (items_sent < RANDOM_ITEMS) begin
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8)) send_item(8'($urandom_range(0, 255)),
                                                 1'($urandom_range(0, 1)));
      end else begin
        send_text();
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    quiet_out = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire

// File: sim.f
+incdir+hw/rtl
hw/rtl/tcf_pkg.sv
hw/rtl/tcf_if.sv
hw/rtl/tcf_front.sv
hw/rtl/tcf_cmd_queue.sv
hw/rtl/tcf_back.sv
hw/rtl/text_cleanup_filter_unit.sv
test/text_cleanup_filter_unit_tb.sv
